FILE: src/mpg_pkg.sv
// Shared constants, types and helpers of the memory pressure governor.
package mpg_pkg;

  localparam int BYTE_BITS_DEF = 48;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_W     = 4;
  localparam int COUNT_W       = 16;

  // Pressure level codes as they appear on the result word.
  localparam logic [1:0] LVL_NORMAL    = 2'd0;
  localparam logic [1:0] LVL_PRESSURE  = 2'd1;
  localparam logic [1:0] LVL_EMERGENCY = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EM_ENTER  = 4'd0,
    REG_EM_EXIT   = 4'd1,
    REG_PR_ENTER  = 4'd2,
    REG_PR_EXIT   = 4'd3,
    REG_EM_TARGET = 4'd4,
    REG_PR_TARGET = 4'd5,
    REG_RECOVERY  = 4'd6,
    REG_HEADROOM  = 4'd7
  } reg_index_t;

  // Threshold and target reset values in Q16; rescaled to the configured fraction width.
  localparam logic [63:0] RST_EM_ENTER  = 64'd62259;
  localparam logic [63:0] RST_EM_EXIT   = 64'd58982;
  localparam logic [63:0] RST_PR_ENTER  = 64'd55706;
  localparam logic [63:0] RST_PR_EXIT   = 64'd52429;
  localparam logic [63:0] RST_EM_TARGET = 64'd52429;
  localparam logic [63:0] RST_PR_TARGET = 64'd58982;
  localparam logic [COUNT_W-1:0] RST_RECOVERY = 16'd4;

  function automatic logic [63:0] rescale(input logic [63:0] v, input int frac);
    return (v << frac) >> 16;
  endfunction

  // Ratio decisions passed from the compare stage to the level stage.
  typedef struct packed {
    logic budget_zero;
    logic ge_em_enter;
    logic ge_em_exit;
    logic ge_pr_enter;
    logic ge_pr_exit;
    logic cap_on;
  } ratio_flags_t;

endpackage

FILE: src/mpg_ratio.sv
// Compare stage: exact ratio compares, scaled targets and headroom cap.
module mpg_ratio #(
  parameter int BYTE_BITS = mpg_pkg::BYTE_BITS_DEF,
  parameter int FRAC_BITS = mpg_pkg::FRAC_BITS_DEF
) (
  input  logic [BYTE_BITS-1:0] budget,
  input  logic [BYTE_BITS-1:0] usage,
  input  logic [FRAC_BITS+1:0] em_enter,
  input  logic [FRAC_BITS+1:0] em_exit,
  input  logic [FRAC_BITS+1:0] pr_enter,
  input  logic [FRAC_BITS+1:0] pr_exit,
  input  logic [FRAC_BITS:0]   em_target,
  input  logic [FRAC_BITS:0]   pr_target,
  input  logic [BYTE_BITS-1:0] headroom,
  output mpg_pkg::ratio_flags_t flags,
  output logic [BYTE_BITS-1:0] em_scaled,
  output logic [BYTE_BITS-1:0] pr_scaled,
  output logic [BYTE_BITS-1:0] cap
);

  localparam int PW = BYTE_BITS + FRAC_BITS + 2;
  localparam int TW = BYTE_BITS + FRAC_BITS + 1;

  logic [PW-1:0] lhs;
  logic [PW-1:0] p_em_enter;
  logic [PW-1:0] p_em_exit;
  logic [PW-1:0] p_pr_enter;
  logic [PW-1:0] p_pr_exit;
  logic [TW-1:0] p_em_tgt;
  logic [TW-1:0] p_pr_tgt;

  // usage * 2^F against budget * threshold, no division.
  assign lhs        = PW'(usage) << FRAC_BITS;
  assign p_em_enter = PW'(budget) * PW'(em_enter);
  assign p_em_exit  = PW'(budget) * PW'(em_exit);
  assign p_pr_enter = PW'(budget) * PW'(pr_enter);
  assign p_pr_exit  = PW'(budget) * PW'(pr_exit);

  // A target of one or more (top bit set) stands for the whole budget.
  assign p_em_tgt  = TW'(budget) * TW'(em_target);
  assign p_pr_tgt  = TW'(budget) * TW'(pr_target);
  assign em_scaled = em_target[FRAC_BITS] ? budget : p_em_tgt[TW-2:FRAC_BITS];
  assign pr_scaled = pr_target[FRAC_BITS] ? budget : p_pr_tgt[TW-2:FRAC_BITS];

  assign cap = (budget > headroom) ? budget - headroom : '0;

  always_comb begin
    flags.budget_zero = (budget == '0);
    flags.ge_em_enter = (lhs >= p_em_enter);
    flags.ge_em_exit  = (lhs >= p_em_exit);
    flags.ge_pr_enter = (lhs >= p_pr_enter);
    flags.ge_pr_exit  = (lhs >= p_pr_exit);
    flags.cap_on      = (headroom != '0);
  end

endmodule

FILE: src/mpg_level.sv
// Level stage: hysteresis state machine, recovery counter and free byte figure.
module mpg_level #(
  parameter int BYTE_BITS = mpg_pkg::BYTE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  mpg_pkg::ratio_flags_t         flags,
  input  logic [BYTE_BITS-1:0]          em_scaled,
  input  logic [BYTE_BITS-1:0]          pr_scaled,
  input  logic [BYTE_BITS-1:0]          cap,
  input  logic [BYTE_BITS-1:0]          usage,
  input  logic [mpg_pkg::COUNT_W-1:0]   recovery_count,
  output logic [1:0]                    level,
  output logic [BYTE_BITS-1:0]          free_bytes
);

  typedef enum logic [1:0] {
    NORMAL    = mpg_pkg::LVL_NORMAL,
    PRESSURE  = mpg_pkg::LVL_PRESSURE,
    EMERGENCY = mpg_pkg::LVL_EMERGENCY
  } state_t;

  state_t                        state, state_next;
  logic [mpg_pkg::COUNT_W-1:0]   stable_count, stable_count_next;
  logic [mpg_pkg::COUNT_W-1:0]   bumped;
  logic [BYTE_BITS-1:0]          target;
  logic [BYTE_BITS-1:0]          free_bytes_next;

  assign bumped = (stable_count == '1) ? stable_count : stable_count + 1'b1;

  always_comb begin
    state_next        = state;
    stable_count_next = stable_count;
    if (flags.budget_zero || flags.ge_em_enter) begin
      state_next        = EMERGENCY;
      stable_count_next = '0;
    end else begin
      case (state)
        EMERGENCY: begin
          if (flags.ge_em_exit) begin
            stable_count_next = '0;
          end else if (bumped >= recovery_count) begin
            state_next        = PRESSURE;
            stable_count_next = '0;
          end else begin
            stable_count_next = bumped;
          end
        end
        PRESSURE: begin
          if (flags.ge_pr_exit) begin
            stable_count_next = '0;
          end else if (bumped >= recovery_count) begin
            state_next        = NORMAL;
            stable_count_next = '0;
          end else begin
            stable_count_next = bumped;
          end
        end
        NORMAL: begin
          if (flags.ge_pr_enter) begin
            state_next        = PRESSURE;
            stable_count_next = '0;
          end
        end
        default: begin
          state_next        = NORMAL;
          stable_count_next = '0;
        end
      endcase
    end
  end

  always_comb begin
    target = (state_next == EMERGENCY) ? em_scaled : pr_scaled;
    if (flags.cap_on && cap < target) begin
      target = cap;
    end
    if (state_next != NORMAL && !flags.budget_zero && usage > target) begin
      free_bytes_next = usage - target;
    end else begin
      free_bytes_next = '0;
    end
  end

  // The state register doubles as the level field of the result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= NORMAL;
      stable_count <= '0;
    end else if (load) begin
      state        <= state_next;
      stable_count <= stable_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      free_bytes <= free_bytes_next;
    end
  end

  assign level = state;

endmodule

FILE: src/memory_pressure_governor.sv
// Top level: stream ports, configuration registers and the three-register pipeline.
// A result word passes the input, compare and level registers in turn before it is valid.
// Throughput: one word per cycle while m_tready is high, set by the single pass from compare stage to level stage.
// Each stage holds its word while the next is full, so bubbles are filled under back-pressure.
// Reset (rst, synchronous) restores register defaults, normal level and a zero stable count.
// No clearing pass is needed; the block takes words on the first cycle after reset.
module memory_pressure_governor #(
  parameter int BYTE_BITS = mpg_pkg::BYTE_BITS_DEF,
  parameter int FRAC_BITS = mpg_pkg::FRAC_BITS_DEF,
  localparam int IN_W  = ((2 * BYTE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((BYTE_BITS + 2 + 7) / 8) * 8,
  localparam int CFG_W = (BYTE_BITS > FRAC_BITS + 2) ? BYTE_BITS : FRAC_BITS + 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [IN_W-1:0]               s_tdata,  // budget_bytes, usage_bytes, zero pad
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [OUT_W-1:0]              m_tdata,  // level, free_bytes, zero pad
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mpg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]              cfg_data
);

  localparam int TH_W = FRAC_BITS + 2;
  localparam int TG_W = FRAC_BITS + 1;

  logic [TH_W-1:0]             em_enter, em_exit, pr_enter, pr_exit;
  logic [TG_W-1:0]             em_target, pr_target;
  logic [mpg_pkg::COUNT_W-1:0] recovery_count;
  logic [BYTE_BITS-1:0]        headroom;

  logic                        in_valid, a_valid;
  logic                        in_free, a_free, out_free;
  logic [BYTE_BITS-1:0]        budget_q, usage_q;

  mpg_pkg::ratio_flags_t       flags_c, flags_a;
  logic [BYTE_BITS-1:0]        em_scaled_c, pr_scaled_c, cap_c;
  logic [BYTE_BITS-1:0]        em_scaled_a, pr_scaled_a, cap_a, usage_a;

  logic [1:0]                  level;
  logic [BYTE_BITS-1:0]        free_bytes;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      em_enter       <= TH_W'(mpg_pkg::rescale(mpg_pkg::RST_EM_ENTER, FRAC_BITS));
      em_exit        <= TH_W'(mpg_pkg::rescale(mpg_pkg::RST_EM_EXIT, FRAC_BITS));
      pr_enter       <= TH_W'(mpg_pkg::rescale(mpg_pkg::RST_PR_ENTER, FRAC_BITS));
      pr_exit        <= TH_W'(mpg_pkg::rescale(mpg_pkg::RST_PR_EXIT, FRAC_BITS));
      em_target      <= TG_W'(mpg_pkg::rescale(mpg_pkg::RST_EM_TARGET, FRAC_BITS));
      pr_target      <= TG_W'(mpg_pkg::rescale(mpg_pkg::RST_PR_TARGET, FRAC_BITS));
      recovery_count <= mpg_pkg::RST_RECOVERY;
      headroom       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (mpg_pkg::reg_index_t'(cfg_index))
        mpg_pkg::REG_EM_ENTER:  em_enter       <= cfg_data[TH_W-1:0];
        mpg_pkg::REG_EM_EXIT:   em_exit        <= cfg_data[TH_W-1:0];
        mpg_pkg::REG_PR_ENTER:  pr_enter       <= cfg_data[TH_W-1:0];
        mpg_pkg::REG_PR_EXIT:   pr_exit        <= cfg_data[TH_W-1:0];
        mpg_pkg::REG_EM_TARGET: em_target      <= cfg_data[TG_W-1:0];
        mpg_pkg::REG_PR_TARGET: pr_target      <= cfg_data[TG_W-1:0];
        mpg_pkg::REG_RECOVERY:  recovery_count <= cfg_data[mpg_pkg::COUNT_W-1:0];
        mpg_pkg::REG_HEADROOM:  headroom       <= cfg_data[BYTE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // A stage may take a new word when it is empty or its word moves on.
  assign out_free = !m_tvalid || m_tready;
  assign a_free   = !a_valid || out_free;
  assign in_free  = !in_valid || a_free;
  assign s_tready = in_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      a_valid  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (in_free) begin
        in_valid <= s_tvalid;
      end
      if (a_free) begin
        a_valid <= in_valid;
      end
      if (out_free) begin
        m_tvalid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && in_free) begin
      budget_q <= s_tdata[BYTE_BITS-1:0];
      usage_q  <= s_tdata[2*BYTE_BITS-1:BYTE_BITS];
    end
    if (in_valid && a_free) begin
      flags_a     <= flags_c;
      em_scaled_a <= em_scaled_c;
      pr_scaled_a <= pr_scaled_c;
      cap_a       <= cap_c;
      usage_a     <= usage_q;
    end
  end

  mpg_ratio #(
    .BYTE_BITS(BYTE_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_ratio (
    .budget    (budget_q),
    .usage     (usage_q),
    .em_enter  (em_enter),
    .em_exit   (em_exit),
    .pr_enter  (pr_enter),
    .pr_exit   (pr_exit),
    .em_target (em_target),
    .pr_target (pr_target),
    .headroom  (headroom),
    .flags     (flags_c),
    .em_scaled (em_scaled_c),
    .pr_scaled (pr_scaled_c),
    .cap       (cap_c)
  );

  mpg_level #(
    .BYTE_BITS(BYTE_BITS)
  ) u_level (
    .clk            (clk),
    .rst            (rst),
    .load           (a_valid && out_free),
    .flags          (flags_a),
    .em_scaled      (em_scaled_a),
    .pr_scaled      (pr_scaled_a),
    .cap            (cap_a),
    .usage          (usage_a),
    .recovery_count (recovery_count),
    .level          (level),
    .free_bytes     (free_bytes)
  );

  assign m_tdata = OUT_W'({free_bytes, level});

endmodule

FILE: src/mpg_checker.sv
// Port-level checks of the governor, bound to the top level.
module mpg_checker #(
  parameter int BYTE_BITS = mpg_pkg::BYTE_BITS_DEF,
  localparam int OUT_W = ((BYTE_BITS + 2 + 7) / 8) * 8
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [OUT_W-1:0]              m_tdata
);

  logic [1:0]           out_level;
  logic [BYTE_BITS-1:0] out_free;

  assign out_level = m_tdata[1:0];
  assign out_free  = m_tdata[BYTE_BITS+1:2];

  // The unused level code never leaves the block.
  a_level_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_level == mpg_pkg::LVL_NORMAL || out_level == mpg_pkg::LVL_PRESSURE ||
                  out_level == mpg_pkg::LVL_EMERGENCY))
    else $error("result word carries an unused level code");

  // Nothing is to be freed at normal level.
  a_normal_free: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_level == mpg_pkg::LVL_NORMAL) |-> (out_free == '0))
    else $error("free byte count is nonzero at normal level");

  // With the output register empty the pipeline can always take a word.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled although no result word is pending");

  // A stalled result word stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result word changed while stalled");

endmodule

bind memory_pressure_governor mpg_checker #(
  .BYTE_BITS(BYTE_BITS)
) u_mpg_checker (.*);
